// ----- rtl/core/fst_pkg.sv -----
package fst_pkg;

    localparam int BUCKETS     = 1024;
    localparam int WAYS        = 4;
    localparam int BUCKET_BITS = $clog2(BUCKETS);
    localparam int WAY_BITS    = $clog2(WAYS);
    localparam int KEY_W       = 96;
    localparam int STAMP_W     = 32;
    localparam int KEY_BYTES   = KEY_W / 8;
    localparam int BYTE_CNT_W  = $clog2(KEY_BYTES);
    localparam int COUNT_W     = 13;
    localparam int DEPTH_W     = 2;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [31:0] HASH_MULT = 32'd16777619;
    localparam logic [31:0] AGE_RESET = 32'd300;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};

    typedef enum logic {
        CMD_PACKET = 1'b0,
        CMD_SWEEP  = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        ST_HIT   = 3'd0,
        ST_NEW   = 3'd1,
        ST_CHAIN = 3'd2,
        ST_DROP  = 3'd3,
        ST_SWEEP = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_HASH,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_PRD,
        B_PEVAL,
        B_SRD,
        B_SEVAL,
        B_SDONE
    } back_state_t;

    typedef struct packed {
        cmd_t                   cmd;
        logic [KEY_W-1:0]       key;
        logic [STAMP_W-1:0]     now;
        logic [BUCKET_BITS-1:0] bucket;
    } job_t;

    function automatic logic [WAY_BITS:0] pop_ways(input logic [WAYS-1:0] bits);
        logic [WAY_BITS:0] n;
        n = '0;
        for (int i = 0; i < WAYS; i++) begin
            n = n + {{WAY_BITS{1'b0}}, bits[i]};
        end
        return n;
    endfunction

endpackage

// ----- rtl/core/fst_front.sv -----
module fst_front import fst_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_cmd,
    input  logic [31:0]            s_src_ip,
    input  logic [31:0]            s_dst_ip,
    input  logic [15:0]            s_src_port,
    input  logic [15:0]            s_dst_port,
    input  logic [31:0]            s_now_seconds,
    output logic                   push_valid,
    input  logic                   push_ready,
    output job_t                   push_job
);

    front_state_t            state_reg, state_next;
    logic [KEY_W-1:0]        key_reg, key_next;
    logic [KEY_W-1:0]        sh_reg, sh_next;
    logic [31:0]             hash_reg, hash_next;
    logic [BYTE_CNT_W-1:0]   byte_reg, byte_next;
    cmd_t                    cmd_reg, cmd_next;
    logic [STAMP_W-1:0]      now_reg, now_next;
    logic [31:0]             prod;

    assign prod = hash_reg * HASH_MULT;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
        key_reg  <= key_next;
        sh_reg   <= sh_next;
        hash_reg <= hash_next;
        byte_reg <= byte_next;
        cmd_reg  <= cmd_next;
        now_reg  <= now_next;
    end

    always_comb begin
        state_next = state_reg;
        key_next   = key_reg;
        sh_next    = sh_reg;
        hash_next  = hash_reg;
        byte_next  = byte_reg;
        cmd_next   = cmd_reg;
        now_next   = now_reg;
        s_ready    = 1'b0;
        push_valid = 1'b0;
        case (state_reg)
            F_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    key_next   = {s_src_ip, s_dst_ip, s_src_port, s_dst_port};
                    sh_next    = {s_src_ip, s_dst_ip, s_src_port, s_dst_port};
                    hash_next  = '0;
                    byte_next  = '0;
                    cmd_next   = cmd_t'(s_cmd);
                    now_next   = s_now_seconds;
                    state_next = (cmd_t'(s_cmd) == CMD_SWEEP) ? F_PUSH : F_HASH;
                end
            end
            F_HASH: begin
                hash_next = prod ^ {24'd0, sh_reg[KEY_W-1 -: 8]};
                sh_next   = {sh_reg[KEY_W-9:0], 8'd0};
                byte_next = byte_reg + 1'b1;
                if (byte_reg == BYTE_CNT_W'(KEY_BYTES - 1)) begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH: begin
                push_valid = 1'b1;
                if (push_ready) begin
                    state_next = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_comb begin
        push_job.cmd    = cmd_reg;
        push_job.key    = key_reg;
        push_job.now    = now_reg;
        push_job.bucket = hash_reg[BUCKET_BITS-1:0];
    end

endmodule

// ----- rtl/core/fst_queue.sv -----
module fst_queue import fst_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  job_t in_job,
    output logic out_valid,
    input  logic out_ready,
    output job_t out_job
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             q_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             push, pop;

    assign in_ready  = cnt_reg != CNT_W'(QUEUE_DEPTH);
    assign out_valid = cnt_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_job   = q_mem[rd_reg];

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wr_next = (wr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop) begin
            rd_next = (rd_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_reg] <= in_job;
        end
    end

endmodule

// ----- rtl/core/fst_back.sv -----
module fst_back import fst_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [31:0]            age_threshold,
    input  logic                   job_valid,
    output logic                   job_ready,
    input  job_t                   job,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [2:0]             m_status,
    output logic [BUCKET_BITS-1:0] m_bucket_index,
    output logic [WAY_BITS-1:0]    m_way_index,
    output logic [COUNT_W-1:0]     m_entry_count,
    output logic [COUNT_W-1:0]     m_unchained_count,
    output logic [COUNT_W-1:0]     m_chained_count,
    output logic [DEPTH_W-1:0]     m_longest_chain,
    output logic [COUNT_W-1:0]     m_expired_count
);

    logic [WAYS*KEY_W-1:0]   key_mem   [BUCKETS];
    logic [WAYS*STAMP_W-1:0] stamp_mem [BUCKETS];
    logic [2*WAYS-1:0]       flag_mem  [BUCKETS];

    logic [WAYS*KEY_W-1:0]   key_rd_reg;
    logic [WAYS*STAMP_W-1:0] stamp_rd_reg;
    logic [2*WAYS-1:0]       flag_rd_reg;

    logic [BUCKET_BITS-1:0]  rd_addr, wr_addr;
    logic                    key_we, stamp_we, flag_we;
    logic [WAYS*KEY_W-1:0]   key_wdata;
    logic [WAYS*STAMP_W-1:0] stamp_wdata;
    logic [2*WAYS-1:0]       flag_wdata;

    back_state_t             state_reg, state_next;
    job_t                    job_reg, job_next;
    logic [BUCKET_BITS-1:0]  row_reg, row_next;
    logic [COUNT_W-1:0]      ent_reg, ent_next;
    logic [COUNT_W-1:0]      unch_reg, unch_next;
    logic [COUNT_W-1:0]      chn_reg, chn_next;
    logic [DEPTH_W-1:0]      deep_reg, deep_next;
    logic [COUNT_W-1:0]      exp_reg, exp_next;

    logic                    m_valid_reg, m_valid_next;
    status_t                 st_reg, st_next;
    logic [BUCKET_BITS-1:0]  ob_reg, ob_next;
    logic [WAY_BITS-1:0]     ow_reg, ow_next;
    logic [COUNT_W-1:0]      oent_reg, oent_next;
    logic [COUNT_W-1:0]      ounch_reg, ounch_next;
    logic [COUNT_W-1:0]      ochn_reg, ochn_next;
    logic [DEPTH_W-1:0]      odeep_reg, odeep_next;
    logic [COUNT_W-1:0]      oexp_reg, oexp_next;

    logic [WAYS-1:0]         valid_row, chain_row, match, expire;
    logic                    hit, have_free;
    logic [WAY_BITS-1:0]     hit_way, free_way;
    logic [WAY_BITS:0]       used, used_m1, exp_unch, exp_chn, exp_all;
    logic [DEPTH_W-1:0]      depth;
    logic                    out_free;

    assign valid_row = flag_rd_reg[WAYS-1:0];
    assign chain_row = flag_rd_reg[2*WAYS-1:WAYS];
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        hit       = 1'b0;
        have_free = 1'b0;
        hit_way   = '0;
        free_way  = '0;
        for (int w = 0; w < WAYS; w++) begin
            match[w]  = valid_row[w] && (key_rd_reg[w*KEY_W +: KEY_W] == job_reg.key);
            expire[w] = valid_row[w] &&
                        ((job_reg.now - stamp_rd_reg[w*STAMP_W +: STAMP_W]) >= age_threshold);
            if (match[w] && !hit) begin
                hit     = 1'b1;
                hit_way = WAY_BITS'(w);
            end
            if (!valid_row[w] && !have_free) begin
                have_free = 1'b1;
                free_way  = WAY_BITS'(w);
            end
        end
        used     = pop_ways(valid_row);
        used_m1  = used - 1'b1;
        depth    = (used_m1 > (WAY_BITS+1)'(DEPTH_MAX)) ? DEPTH_MAX : DEPTH_W'(used_m1);
        exp_unch = pop_ways(expire & ~chain_row);
        exp_chn  = pop_ways(expire & chain_row);
        exp_all  = pop_ways(expire);
    end

    always_ff @(posedge aclk) begin
        key_rd_reg <= key_mem[rd_addr];
        if (key_we) begin
            key_mem[wr_addr] <= key_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        stamp_rd_reg <= stamp_mem[rd_addr];
        if (stamp_we) begin
            stamp_mem[wr_addr] <= stamp_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        flag_rd_reg <= flag_mem[rd_addr];
        if (flag_we) begin
            flag_mem[wr_addr] <= flag_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_CLEAR;
            row_reg     <= '0;
            ent_reg     <= '0;
            unch_reg    <= '0;
            chn_reg     <= '0;
            deep_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            row_reg     <= row_next;
            ent_reg     <= ent_next;
            unch_reg    <= unch_next;
            chn_reg     <= chn_next;
            deep_reg    <= deep_next;
            m_valid_reg <= m_valid_next;
        end
        job_reg   <= job_next;
        exp_reg   <= exp_next;
        st_reg    <= st_next;
        ob_reg    <= ob_next;
        ow_reg    <= ow_next;
        oent_reg  <= oent_next;
        ounch_reg <= ounch_next;
        ochn_reg  <= ochn_next;
        odeep_reg <= odeep_next;
        oexp_reg  <= oexp_next;
    end

    always_comb begin
        state_next   = state_reg;
        job_next     = job_reg;
        row_next     = row_reg;
        ent_next     = ent_reg;
        unch_next    = unch_reg;
        chn_next     = chn_reg;
        deep_next    = deep_reg;
        exp_next     = exp_reg;
        m_valid_next = m_valid_reg && !m_ready;
        st_next      = st_reg;
        ob_next      = ob_reg;
        ow_next      = ow_reg;
        oent_next    = oent_reg;
        ounch_next   = ounch_reg;
        ochn_next    = ochn_reg;
        odeep_next   = odeep_reg;
        oexp_next    = oexp_reg;
        job_ready    = 1'b0;
        rd_addr      = (state_reg == B_SRD || state_reg == B_SEVAL) ? row_reg : job_reg.bucket;
        wr_addr      = job_reg.bucket;
        key_we       = 1'b0;
        stamp_we     = 1'b0;
        flag_we      = 1'b0;
        key_wdata    = key_rd_reg;
        stamp_wdata  = stamp_rd_reg;
        flag_wdata   = flag_rd_reg;
        case (state_reg)
            B_CLEAR: begin
                wr_addr    = row_reg;
                flag_we    = 1'b1;
                flag_wdata = '0;
                row_next   = row_reg + 1'b1;
                if (row_reg == BUCKET_BITS'(BUCKETS - 1)) begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE: begin
                job_ready = 1'b1;
                if (job_valid) begin
                    job_next = job;
                    row_next = '0;
                    exp_next = '0;
                    state_next = (job.cmd == CMD_SWEEP) ? B_SRD : B_PRD;
                end
            end
            B_PRD: begin
                state_next = B_PEVAL;
            end
            B_PEVAL: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    ob_next      = job_reg.bucket;
                    oexp_next    = '0;
                    ow_next      = '0;
                    oent_next    = ent_reg;
                    ounch_next   = unch_reg;
                    ochn_next    = chn_reg;
                    odeep_next   = deep_reg;
                    if (hit) begin
                        st_next  = ST_HIT;
                        ow_next  = hit_way;
                        stamp_we = 1'b1;
                        stamp_wdata[hit_way*STAMP_W +: STAMP_W] = job_reg.now;
                    end else if (!have_free) begin
                        st_next = ST_DROP;
                    end else begin
                        ow_next  = free_way;
                        key_we   = 1'b1;
                        stamp_we = 1'b1;
                        flag_we  = 1'b1;
                        key_wdata[free_way*KEY_W +: KEY_W]       = job_reg.key;
                        stamp_wdata[free_way*STAMP_W +: STAMP_W] = job_reg.now;
                        flag_wdata[free_way]                     = 1'b1;
                        flag_wdata[WAYS + 32'(free_way)]         = (used != '0);
                        ent_next  = ent_reg + 1'b1;
                        oent_next = ent_reg + 1'b1;
                        if (used == '0) begin
                            st_next    = ST_NEW;
                            unch_next  = unch_reg + 1'b1;
                            ounch_next = unch_reg + 1'b1;
                        end else begin
                            st_next   = ST_CHAIN;
                            chn_next  = chn_reg + 1'b1;
                            ochn_next = chn_reg + 1'b1;
                            if (depth > deep_reg) begin
                                deep_next  = depth;
                                odeep_next = depth;
                            end
                        end
                    end
                    state_next = B_IDLE;
                end
            end
            B_SRD: begin
                state_next = B_SEVAL;
            end
            B_SEVAL: begin
                wr_addr    = row_reg;
                flag_we    = 1'b1;
                flag_wdata = {chain_row & ~expire, valid_row & ~expire};
                ent_next   = ent_reg - COUNT_W'(exp_all);
                unch_next  = unch_reg - COUNT_W'(exp_unch);
                chn_next   = chn_reg - COUNT_W'(exp_chn);
                exp_next   = exp_reg + COUNT_W'(exp_all);
                row_next   = row_reg + 1'b1;
                state_next = (row_reg == BUCKET_BITS'(BUCKETS - 1)) ? B_SDONE : B_SRD;
            end
            B_SDONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    st_next      = ST_SWEEP;
                    ob_next      = '0;
                    ow_next      = '0;
                    oent_next    = ent_reg;
                    ounch_next   = unch_reg;
                    ochn_next    = chn_reg;
                    odeep_next   = deep_reg;
                    oexp_next    = exp_reg;
                    state_next   = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = st_reg;
    assign m_bucket_index    = ob_reg;
    assign m_way_index       = ow_reg;
    assign m_entry_count     = oent_reg;
    assign m_unchained_count = ounch_reg;
    assign m_chained_count   = ochn_reg;
    assign m_longest_chain   = odeep_reg;
    assign m_expired_count   = oexp_reg;

`ifndef SYNTHESIS
    a_count_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        ent_reg == unch_reg + chn_reg)
        else $error("Session total differs from the sum of its classes.");

    a_no_pop_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == B_CLEAR |-> !job_ready)
        else $error("A word was taken during the clearing pass.");

    a_deep_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> deep_reg >= $past(deep_reg))
        else $error("Longest chain decreased.");

    a_sweep_result: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == B_SDONE && out_free |=> m_valid_reg && st_reg == ST_SWEEP)
        else $error("Sweep ended without its result.");
`endif

endmodule

// ----- rtl/core/flow_session_table_unit.sv -----
// Packet word: the front part takes no new word until it has hashed and pushed the last;
// its hash is byte-serial, FNV-1 prime from a zero start, one 32x32 multiply per byte.
// Sweep word: the back part reads each bucket row in turn from the table memories
// and rewrites its valid and chain flags, clearing those of expired entries.
// Reset is synchronous and active low; afterwards a clearing pass over all 1024 rows
// zeroes the valid and chain flags. Up to three words taken meanwhile wait until it ends.
module flow_session_table_unit import fst_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [31:0]            cfg_wr_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_cmd,
    input  logic [31:0]            s_src_ip,
    input  logic [31:0]            s_dst_ip,
    input  logic [15:0]            s_src_port,
    input  logic [15:0]            s_dst_port,
    input  logic [31:0]            s_now_seconds,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [2:0]             m_status,
    output logic [BUCKET_BITS-1:0] m_bucket_index,
    output logic [WAY_BITS-1:0]    m_way_index,
    output logic [COUNT_W-1:0]     m_entry_count,
    output logic [COUNT_W-1:0]     m_unchained_count,
    output logic [COUNT_W-1:0]     m_chained_count,
    output logic [DEPTH_W-1:0]     m_longest_chain,
    output logic [COUNT_W-1:0]     m_expired_count
);

    logic [31:0] age_reg;
    logic        push_valid, push_ready, pop_valid, pop_ready;
    job_t        push_job, pop_job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            age_reg <= AGE_RESET;
        end else if (cfg_wr_en) begin
            age_reg <= cfg_wr_data;
        end
    end

    fst_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_src_ip      (s_src_ip),
        .s_dst_ip      (s_dst_ip),
        .s_src_port    (s_src_port),
        .s_dst_port    (s_dst_port),
        .s_now_seconds (s_now_seconds),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_job      (push_job)
    );

    fst_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_job    (push_job),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_job   (pop_job)
    );

    fst_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .age_threshold     (age_reg),
        .job_valid         (pop_valid),
        .job_ready         (pop_ready),
        .job               (pop_job),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_bucket_index    (m_bucket_index),
        .m_way_index       (m_way_index),
        .m_entry_count     (m_entry_count),
        .m_unchained_count (m_unchained_count),
        .m_chained_count   (m_chained_count),
        .m_longest_chain   (m_longest_chain),
        .m_expired_count   (m_expired_count)
    );

endmodule
